### sv/lfsa_pkg.sv
package lfsa_pkg;

	// sizes of the owner table and the free map
	localparam int unsigned OWNERS = 1024;
	localparam int unsigned SLOTS  = 1024;

	// field widths on the ports
	localparam int unsigned ID_W = 10;
	localparam int unsigned SO_W = 10;

	localparam int unsigned OWN_W  = (OWNERS > 1) ? $clog2(OWNERS) : 1;
	localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// free map kept as rows of up to 32 slots, one summary bit per row
	localparam int unsigned WORD_W = (SLOTS < 32) ? SLOTS : 32;
	localparam int unsigned BIT_W  = (WORD_W > 1) ? $clog2(WORD_W) : 1;
	localparam int unsigned ROWS   = (SLOTS + WORD_W - 1) / WORD_W;
	localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

	// clearing pass covers both tables
	localparam int unsigned CLEAR_LEN = (OWNERS > ROWS) ? OWNERS : ROWS;
	localparam int unsigned CLR_W     = (CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_FREE     = 2'd1,
		ST_NOT_HOLDING = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_READY,
		S_LOOKUP,
		S_FREE,
		S_PUSH
	} fsm_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic lookup;
		logic release_slot;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic leave_hit;
	} sts_t;

	// lowest set bit of the row summary
	function automatic logic [ROW_W-1:0] first_row(input logic [ROWS-1:0] v);
		logic [ROW_W-1:0] r;
		r = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (v[i]) r = ROW_W'(i);
		end
		return r;
	endfunction

	// lowest set bit within one row
	function automatic logic [BIT_W-1:0] first_bit(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) r = BIT_W'(i);
		end
		return r;
	endfunction

	// free pattern of a row after reset: bits past the last slot stay clear
	function automatic logic [WORD_W-1:0] row_init(input int unsigned r);
		logic [WORD_W-1:0] w;
		for (int b = 0; b < WORD_W; b++) begin
			w[b] = ((r * WORD_W + b) < SLOTS);
		end
		return w;
	endfunction

endpackage

### sv/lfsa_ctrl.sv
module lfsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  lfsa_pkg::sts_t sts,
	output lfsa_pkg::cmd_t cmd
);
	import lfsa_pkg::*;

	fsm_t state_q, state_d;
	logic out_valid_q;

	// state register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) state_d = S_READY;
			end
			S_READY: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = sts.leave_hit ? S_FREE : S_PUSH;
			end
			S_FREE: begin
				cmd.release_slot = 1'b1;
				state_d          = S_PUSH;
			end
			S_PUSH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_READY;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	assign in_stall  = (state_q != S_READY);
	assign out_valid = out_valid_q;

endmodule

### sv/lfsa_dp.sv
module lfsa_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lfsa_pkg::cmd_t            cmd,
	output lfsa_pkg::sts_t            sts,
	input  logic                      cfg_we,
	input  logic [lfsa_pkg::ID_W-1:0] cfg_wdata,
	input  logic                      func,
	input  logic [lfsa_pkg::ID_W-1:0] owner,
	output logic [lfsa_pkg::SO_W-1:0] slot,
	output logic [1:0]                status,
	output logic                      is_target
);
	import lfsa_pkg::*;

	// tables
	logic [SLOT_W:0]     own_mem [OWNERS];
	logic [WORD_W-1:0]   free_mem [ROWS];
	logic [ROWS-1:0]     summary_q;

	// configuration and clearing pass
	logic [ID_W-1:0]     target_q;
	logic [CLR_W-1:0]    clr_q;

	// event latched at transfer
	logic                func_q;
	logic [ID_W-1:0]     owner_q;
	logic [OWN_W-1:0]    oidx_q;
	logic                ovalid_q;
	logic [ROW_W-1:0]    row_q;
	logic                any_q;
	logic [SLOT_W:0]     own_rd_q;
	logic [WORD_W-1:0]   free_rd_q;

	// slot being released
	logic [ROW_W-1:0]    rel_row_q;
	logic [BIT_W-1:0]    rel_bit_q;

	// pending and output result
	logic [SLOT_W-1:0]   res_slot_q;
	status_t             res_status_q;
	logic                res_tgt_q;
	logic [SO_W-1:0]     slot_q;
	status_t             status_q;
	logic                tgt_q;

	logic [OWN_W+ID_W-1:0]   own_ext;
	logic [OWN_W-1:0]        oidx;
	logic                    ovalid;
	logic                    hold_rd;
	logic [SLOT_W-1:0]       held_rd;
	logic [BIT_W-1:0]        bit_new;
	logic [SLOT_W-1:0]       s_new;
	logic [WORD_W-1:0]       word_taken;
	logic                    arr_take;
	logic                    leave_hit;
	logic [ROW_W-1:0]        held_row;
	logic [BIT_W-1:0]        held_bit;
	logic [SLOT_W-1:0]       res_slot_d;
	status_t                 res_status_d;
	logic [CLR_W:0]          clr_ext;
	logic [SLOT_W+SO_W-1:0]  slot_ext;
	logic [ROW_W-1:0]        free_rd_addr;

	// owner id to table index, ids past the table hold nothing
	assign own_ext = {{OWN_W{1'b0}}, owner};
	assign oidx    = own_ext[OWN_W-1:0];
	assign ovalid  = own_ext < (OWN_W + ID_W)'(OWNERS);

	// lookup decode
	assign hold_rd    = own_rd_q[SLOT_W];
	assign held_rd    = own_rd_q[SLOT_W-1:0];
	assign bit_new    = first_bit(free_rd_q);
	assign s_new      = (SLOT_W'(row_q) << BIT_W) | SLOT_W'(bit_new);
	assign word_taken = free_rd_q & ~(WORD_W'(1) << bit_new);
	assign arr_take   = !func_q && ovalid_q && !hold_rd && any_q;
	assign leave_hit  = func_q && ovalid_q && hold_rd;
	assign held_row   = ROW_W'(held_rd >> BIT_W);
	assign held_bit   = BIT_W'(held_rd);

	always_comb begin
		res_slot_d   = '0;
		res_status_d = ST_OK;
		if (func_q) begin
			if (leave_hit) res_slot_d = held_rd;
			else res_status_d = ST_NOT_HOLDING;
		end else if (!ovalid_q) begin
			res_status_d = ST_NO_FREE;
		end else if (hold_rd) begin
			res_slot_d = held_rd;
		end else if (any_q) begin
			res_slot_d = s_new;
		end else begin
			res_status_d = ST_NO_FREE;
		end
	end

	// clearing pass counter
	assign clr_ext        = {1'b0, clr_q};
	assign sts.clear_last = (clr_q == CLR_W'(CLEAR_LEN - 1));
	assign sts.leave_hit  = leave_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			target_q <= '0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + CLR_W'(1);
			if (cfg_we) target_q <= cfg_wdata;
		end
	end

	// row summary: a bit is set while the row has a free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summary_q <= '1;
		end else if (cmd.lookup && arr_take && (word_taken == '0)) begin
			summary_q[row_q] <= 1'b0;
		end else if (cmd.release_slot) begin
			summary_q[rel_row_q] <= 1'b1;
		end
	end

	// owner table
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			if (clr_ext < (CLR_W + 1)'(OWNERS)) own_mem[clr_q[OWN_W-1:0]] <= '0;
		end else if (cmd.lookup && arr_take) begin
			own_mem[oidx_q] <= {1'b1, s_new};
		end else if (cmd.lookup && leave_hit) begin
			own_mem[oidx_q] <= {1'b0, held_rd};
		end
		if (cmd.accept) own_rd_q <= own_mem[oidx];
	end

	// free map
	assign free_rd_addr = cmd.accept ? first_row(summary_q) : held_row;

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			if (clr_ext < (CLR_W + 1)'(ROWS))
				free_mem[ROW_W'(clr_q)] <= row_init(32'(clr_q));
		end else if (cmd.lookup && arr_take) begin
			free_mem[row_q] <= word_taken;
		end else if (cmd.release_slot) begin
			free_mem[rel_row_q] <= free_rd_q | (WORD_W'(1) << rel_bit_q);
		end
		if (cmd.accept || (cmd.lookup && leave_hit)) free_rd_q <= free_mem[free_rd_addr];
	end

	// event and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q   <= func;
			owner_q  <= owner;
			oidx_q   <= oidx;
			ovalid_q <= ovalid;
			row_q    <= first_row(summary_q);
			any_q    <= |summary_q;
		end
		if (cmd.lookup) begin
			res_slot_q   <= res_slot_d;
			res_status_q <= res_status_d;
			res_tgt_q    <= !func_q && (owner_q == target_q);
			rel_row_q    <= held_row;
			rel_bit_q    <= held_bit;
		end
		if (cmd.load_out) begin
			slot_q   <= slot_ext[SO_W-1:0];
			status_q <= res_status_q;
			tgt_q    <= res_tgt_q;
		end
	end

	// slot numbers leave masked to the port width
	assign slot_ext  = {{SO_W{1'b0}}, res_slot_q};
	assign slot      = slot_q;
	assign status    = status_q;
	assign is_target = tgt_q;

endmodule

### sv/lowest_free_slot_allocator_unit.sv
// channel  | handshake           | payload
// ---------+---------------------+-------------------------
// in       | in_valid / in_stall | func, owner
// out      | out_valid/out_stall | slot, status, is_target
// cfg      | cfg_we              | cfg_wdata (target owner)
//
// An event is taken in the ready state and looked up; its result is loaded into
// the output register from the push state, and the next transfer is taken after
// that. A leave that frees a slot adds a free state for the read-modify-write of
// the released row. After reset a clearing pass as long as the owner table depth
// runs with in_stall high; cfg writes are taken throughout.
// The output register holds one result; a finished event waits in the result
// stage, with in_stall high, while that register is full and out_stall is high.
module lowest_free_slot_allocator_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic [lfsa_pkg::ID_W-1:0] owner,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [lfsa_pkg::SO_W-1:0] slot,
	output logic [1:0]                status,
	output logic                      is_target,
	input  logic                      cfg_we,
	input  logic [lfsa_pkg::ID_W-1:0] cfg_wdata
);
	import lfsa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lfsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lfsa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.func      (func),
		.owner     (owner),
		.slot      (slot),
		.status    (status),
		.is_target (is_target)
	);

	// one event in flight at a time
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transfer accepted while an event is in flight");

	// failed events report slot zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (slot == '0))
		else $error("nonzero slot on a failed event");

	// target flag belongs to arrivals only
	a_target_arr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_target |-> (status != ST_NOT_HOLDING))
		else $error("target flag on a leave");

endmodule
